### hdl/spq_pkg.sv
package spq_pkg;

  localparam int KIND_W   = 8;
  localparam int PRIO_W   = 32;
  localparam int STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_NULL  = 3'd1,
    ST_DUP   = 3'd2,
    ST_FULL  = 3'd3,
    ST_EMPTY = 3'd4
  } spq_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load_item;
    logic        scan_init;
    logic        scan_step;
    logic        shdn_init;
    logic        shdn_step;
    logic        wr_new;
    logic        rd_front;
    logic        cap_front;
    logic        shup_step;
    logic        cnt_inc;
    logic        cnt_dec;
    logic        ld_result;
    spq_status_t status;
  } spq_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic mode_rm;
    logic null_h;
    logic dup;
    logic full;
    logic empty;
    logic idx_at_count;
    logic idx_at_pos;
    logic out_busy;
  } spq_flags_t;

endpackage

### hdl/spq_ctrl.sv
module spq_ctrl
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  spq_flags_t flags,
  output spq_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SCAN_WAIT,
    S_DECIDE,
    S_SHIFT_DN,
    S_DRAIN_IN,
    S_WR_NEW,
    S_RM_RD0,
    S_RM_CAP,
    S_SHIFT_UP,
    S_DRAIN_RM,
    S_FINISH
  } state_t;

  state_t      state_r, state_nxt;
  spq_status_t status_r, status_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.status = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (flags.mode_rm && flags.empty) begin
          status_nxt = ST_EMPTY;
          state_nxt  = S_FINISH;
        end else if (flags.mode_rm) begin
          status_nxt = ST_OK;
          state_nxt  = S_RM_RD0;
        end else if (flags.null_h) begin
          status_nxt = ST_NULL;
          state_nxt  = S_FINISH;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (flags.idx_at_count) begin
          state_nxt = S_SCAN_WAIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SCAN_WAIT: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (flags.dup) begin
          status_nxt = ST_DUP;
          state_nxt  = S_FINISH;
        end else if (flags.full) begin
          status_nxt = ST_FULL;
          state_nxt  = S_FINISH;
        end else begin
          status_nxt    = ST_OK;
          cmd.shdn_init = 1'b1;
          state_nxt     = S_SHIFT_DN;
        end
      end
      S_SHIFT_DN: begin
        if (flags.idx_at_pos) begin
          state_nxt = S_DRAIN_IN;
        end else begin
          cmd.shdn_step = 1'b1;
        end
      end
      S_DRAIN_IN: begin
        state_nxt = S_WR_NEW;
      end
      S_WR_NEW: begin
        cmd.wr_new  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_RM_RD0: begin
        cmd.rd_front = 1'b1;
        state_nxt    = S_RM_CAP;
      end
      S_RM_CAP: begin
        cmd.cap_front = 1'b1;
        state_nxt     = S_SHIFT_UP;
      end
      S_SHIFT_UP: begin
        if (flags.idx_at_count) begin
          state_nxt = S_DRAIN_RM;
        end else begin
          cmd.shup_step = 1'b1;
        end
      end
      S_DRAIN_RM: begin
        cmd.cnt_dec = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        if (!flags.out_busy) begin
          cmd.ld_result = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

### hdl/spq_dp.sv
module spq_dp
  import spq_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int HANDLE_BITS = 16,
  parameter int CW          = $clog2(DEPTH + 1),
  parameter int IN_W        = ((HANDLE_BITS + KIND_W + PRIO_W + 7) / 8) * 8,
  parameter int OUT_W       = ((CW + HANDLE_BITS + KIND_W + PRIO_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IN_W-1:0]     in_tdata,
  input  logic                in_tuser,
  input  spq_cmd_t            cmd,
  output spq_flags_t          flags,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [OUT_W-1:0]    out_tdata,
  output logic [STATUS_W-1:0] out_tuser
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HB = HANDLE_BITS;
  localparam int EW = HB + KIND_W + PRIO_W;

  // Entry layout, lowest bit up: handle, kind, priority.
  logic [EW-1:0] mem [DEPTH];

  logic                     mode_r;
  logic [HB-1:0]            h_r;
  logic [KIND_W-1:0]        k_r;
  logic signed [PRIO_W-1:0] p_r;

  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] pos_r;
  logic [CW-1:0] cmp_idx_r;
  logic          cmp_v_r;
  logic          dup_r;
  logic          found_r;

  logic [EW-1:0] rd_data_r;
  logic          wv_r;
  logic [AW-1:0] wa_r;

  logic [EW-1:0] front_r;

  logic                     out_valid_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic [CW-1:0]            out_count_r;
  logic [EW-1:0]            out_entry_r;

  logic          rd_en;
  logic [CW-1:0] rd_idx;
  logic signed [PRIO_W-1:0] rd_prio;

  assign rd_prio = $signed(rd_data_r[EW-1:HB+KIND_W]);

  always_comb begin
    rd_en  = cmd.scan_step | cmd.shup_step | cmd.shdn_step | cmd.rd_front;
    rd_idx = idx_r;
    if (cmd.shdn_step) begin
      rd_idx = idx_r - CW'(1);
    end else if (cmd.rd_front) begin
      rd_idx = '0;
    end
  end

  // Entry store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wv_r) begin
      mem[wa_r] <= rd_data_r;
    end else if (cmd.wr_new) begin
      mem[pos_r[AW-1:0]] <= {p_r, k_r, h_r};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_r  <= in_tuser;
      h_r     <= in_tdata[HB-1:0];
      k_r     <= in_tdata[HB+KIND_W-1:HB];
      p_r     <= $signed(in_tdata[EW-1:HB+KIND_W]);
      front_r <= '0;
    end else if (cmd.cap_front) begin
      front_r <= rd_data_r;
    end

    if (cmd.scan_init) begin
      idx_r   <= '0;
      pos_r   <= count_r;
      dup_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (cmd.shdn_init) begin
        idx_r <= count_r;
      end else if (cmd.shdn_step) begin
        idx_r <= idx_r - CW'(1);
      end else if (cmd.rd_front) begin
        idx_r <= CW'(1);
      end else if (cmd.scan_step || cmd.shup_step) begin
        idx_r <= idx_r + CW'(1);
      end
      // The first stored entry with a larger priority marks the insert point.
      if (cmp_v_r) begin
        if (rd_data_r[HB-1:0] == h_r) begin
          dup_r <= 1'b1;
        end
        if (!found_r && (rd_prio > p_r)) begin
          found_r <= 1'b1;
          pos_r   <= cmp_idx_r;
        end
      end
    end

    cmp_idx_r <= idx_r;
    if (cmd.shdn_step) begin
      wa_r <= idx_r[AW-1:0];
    end else begin
      wa_r <= rd_idx[AW-1:0] - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cmp_v_r <= 1'b0;
      wv_r    <= 1'b0;
    end else begin
      cmp_v_r <= cmd.scan_step;
      wv_r    <= cmd.shdn_step | cmd.shup_step;
      if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  // Output register: holds one result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_result) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.ld_result) begin
      out_status_r <= cmd.status;
      out_count_r  <= count_r;
      out_entry_r  <= front_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_W'({out_entry_r, out_count_r});

  always_comb begin
    flags.mode_rm      = mode_r;
    flags.null_h       = (h_r == '0);
    flags.dup          = dup_r;
    flags.full         = (count_r == CW'(DEPTH));
    flags.empty        = (count_r == '0);
    flags.idx_at_count = (idx_r == count_r);
    flags.idx_at_pos   = (idx_r == pos_r);
    flags.out_busy     = out_valid_r & ~out_tready;
  end

endmodule

### hdl/stable_priority_queue.sv
// Channel   Direction  Ports                                  Contents
// in_       sink       in_tvalid in_tready in_tdata in_tuser  one operation
// out_      source     out_tvalid out_tready out_tdata out_tuser  one result
//
// Operations: an insert scans every queued entry, then shifts the entries behind
// its place in the queue down by one; a remove shifts all the others up by one;
// the pace of both is set by the entry memory, which moves one entry a cycle.
// Reset: rst_n is synchronous and active low; the queue comes up empty.
// Stalls: a result waits in the output register; the next operation is taken
// and worked on meanwhile, and only its own result waits for that register.
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int HANDLE_BITS = 16,
  // The count field needs to hold DEPTH itself, hence the extra code.
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int IN_W  = ((HANDLE_BITS + KIND_W + PRIO_W + 7) / 8) * 8,
  localparam int OUT_W = ((CW + HANDLE_BITS + KIND_W + PRIO_W + 7) / 8) * 8
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                 in_tvalid,
  output logic                 in_tready,
  // in_tdata, lowest bit up: item_handle, kind, priority_req, zero fill.
  input  logic [IN_W-1:0]      in_tdata,
  // in_tuser: mode (0 insert, 1 remove front entry).
  input  logic                 in_tuser,

  output logic                 out_tvalid,
  input  logic                 out_tready,
  // out_tdata, lowest bit up: count, out_handle, out_kind, out_priority, zero fill.
  output logic [OUT_W-1:0]     out_tdata,
  // out_tuser: status.
  output logic [STATUS_W-1:0]  out_tuser
);

  spq_cmd_t   cmd;
  spq_flags_t flags;

  // The controller sequences each operation: for an insert, a scan for a duplicate
  // handle and the insert point and a shift down to open a gap; for a remove, a
  // shift up to close the gap at the front; finally loading of the result.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .flags     (flags),
    .cmd       (cmd)
  );

  // The datapath holds the sorted entry memory, the count, the scan
  // comparators and the output register.
  spq_dp #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS),
    .CW          (CW),
    .IN_W        (IN_W),
    .OUT_W       (OUT_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .flags      (flags),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Once a transfer is taken the block is busy with it on the next cycle.
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready
  ) else $error("input taken again straight after a transfer");

  // A new entry is never written into a full queue.
  a_no_write_when_full: assert property (
    @(posedge clk) disable iff (!rst_n)
    cmd.wr_new |-> !flags.full
  ) else $error("entry written while the queue is full");

  // A result is never loaded over one that the sink has not yet taken.
  a_no_result_overwrite: assert property (
    @(posedge clk) disable iff (!rst_n)
    cmd.ld_result |-> !flags.out_busy
  ) else $error("pending result overwritten");

  // An empty report always carries a zero count.
  a_empty_count_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_EMPTY)) |-> (out_tdata[CW-1:0] == '0)
  ) else $error("empty status with a non-zero count");

endmodule
